// ===== rtl/smuv_pkg.sv =====
// smuv_pkg: shared widths, constants, types and config register codes
// for the sphere-map texture coordinate pipeline. No dependencies.
package smuv_pkg;

    // vector and magnitude widths
    localparam int IN_W   = 32;
    localparam int MAG_W  = IN_W + 1;
    localparam int NRM_W  = 30;
    localparam int SQR_W  = 2 * NRM_W;
    localparam int T_W    = 17;
    localparam int S_W    = 16;
    localparam int OUT_W  = 16;

    // square root cell state
    localparam int SQ_RAD_W  = 64;
    localparam int SQ_REM_W  = 36;
    localparam int SQ_ROOT_W = 32;

    // divider cell state
    localparam int DIV_R_W = 32;
    localparam int Q_W     = 17;

    // pipeline depths
    localparam int NRM_STAGES  = 5;
    localparam int FRONT_STG   = 4 + NRM_STAGES;
    localparam int LEN_STEPS   = 32;
    localparam int DIV_STEPS   = 17;
    localparam int SEL_STG     = 1;
    localparam int W_STEPS     = 16;
    localparam int ASIN_STG    = 9;
    localparam int HORNER_STG  = 5;
    localparam int LAT = FRONT_STG + LEN_STEPS + DIV_STEPS + SEL_STG + W_STEPS + ASIN_STG;

    localparam logic [T_W-1:0] UNIT_Q16 = 17'd65536;
    localparam logic [T_W-1:0] HALF_Q16 = 17'd32768;

    // series coefficients in Q30
    localparam logic [30:0] K1  = 31'd1073741824;
    localparam logic [30:0] K3  = 31'd178956970;
    localparam logic [30:0] K5  = 31'd80530636;
    localparam logic [30:0] K7  = 31'd47934902;
    localparam logic [30:0] K9  = 31'd32622364;
    localparam logic [30:0] K11 = 31'd24021922;
    localparam logic [30:0] HORNER_K [HORNER_STG] = '{K9, K7, K5, K3, K1};
    localparam logic [28:0] INV_PI_Q30 = 29'd341782638;
    localparam logic [30:0] Q30_HALF   = 31'h2000_0000;
    localparam logic [OUT_W:0] COORD_MAX = 17'd32768;

    typedef enum logic [1:0] {
        CFG_USE_NORMALS = 2'd0,
        CFG_CENTER_X    = 2'd1,
        CFG_CENTER_Y    = 2'd2,
        CFG_CENTER_Z    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [SQ_RAD_W-1:0]  rad;
        logic [SQ_REM_W-1:0]  rem;
        logic [SQ_ROOT_W-1:0] root;
    } t_sqrt_st;

    typedef struct packed {
        logic [SQ_ROOT_W-1:0] len;
        logic [DIV_R_W-1:0]   rx;
        logic [Q_W-1:0]       qx;
        logic [DIV_R_W-1:0]   ry;
        logic [Q_W-1:0]       qy;
    } t_div_st;

    typedef struct packed {
        logic           neg_x;
        logic           neg_y;
        logic           zero;
        logic [T_W-1:0] nx;
        logic [T_W-1:0] ny;
    } t_side;

    typedef struct packed {
        logic [NRM_W-1:0] m0;
        logic [NRM_W-1:0] m1;
        t_side            side;
    } t_mid;

    typedef struct packed {
        logic far_side;
        logic neg;
    } t_asin_ctl;

    typedef struct packed {
        logic [S_W-1:0] tx;
        logic [S_W-1:0] ty;
        t_asin_ctl      cx;
        t_asin_ctl      cy;
    } t_fside;

endpackage

// ===== rtl/sphere_map_uv_generator_top.sv =====
// sphere_map_uv_generator_top: vertex vector in, sphere-mapped u/v out.
// Depends on smuv_pkg, smuv_sqrt_cell, smuv_div_cell, smuv_asin.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------------
//   in       | i_in_valid / o_in_stall   | i_vec_x, i_vec_y, i_vec_z, i_is_last
//   out      | o_out_valid / i_out_stall | o_u_coord, o_v_coord, o_last_out
//   config   | i_cfg_we                  | i_cfg_addr, i_cfg_data
//
// One vertex per cycle while no result is held; each request passes in order through
// the 32-cell length square root, the 17-cell divider, the 16-cell square root
// of the arcsine far side and the 9-stage series.
// Reset clears the config registers and the valid line; nothing else.
// An unaccepted result freezes the whole chain; o_in_stall follows from that.
module sphere_map_uv_generator_top import smuv_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [IN_W-1:0]  i_vec_x,
    input  logic signed [IN_W-1:0]  i_vec_y,
    input  logic signed [IN_W-1:0]  i_vec_z,
    input  logic                    i_is_last,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [OUT_W-1:0]        o_u_coord,
    output logic signed [OUT_W-1:0] o_v_coord,
    output logic                    o_last_out,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_addr,
    input  logic [IN_W-1:0]         i_cfg_data
);

    logic              r_use_normals;
    logic [IN_W-1:0]   r_center_x;
    logic [IN_W-1:0]   r_center_y;
    logic [IN_W-1:0]   r_center_z;

    logic              en;
    logic              accept;
    logic              r_vld [LAT];
    logic              r_lst [LAT];

    logic [IN_W-1:0]   in_v  [3];
    logic [IN_W-1:0]   cen   [3];
    logic [MAG_W-1:0]  a_d   [3];
    logic [MAG_W-1:0]  a_mag [3];
    logic [MAG_W-1:0]  r_am  [3];
    logic              r_aneg_x;
    logic              r_aneg_y;

    logic [MAG_W-1:0]  b_ov;
    logic [1:0]        b_rs;
    t_side             b_side;
    logic [NRM_W-1:0]  r_cm  [NRM_STAGES+1][3];
    t_side             r_cs  [NRM_STAGES+1];

    logic [SQR_W-1:0]  r_dsq [3];
    logic [NRM_W-1:0]  r_dm0;
    logic [NRM_W-1:0]  r_dm1;
    t_side             r_dside;

    t_sqrt_st          r_est;
    t_sqrt_st          l_st  [LEN_STEPS+1];
    t_mid              r_mid [LEN_STEPS+1];

    t_div_st           dv    [DIV_STEPS+1];
    t_side             r_dvs [DIV_STEPS];

    t_side             f_side;
    logic [T_W-1:0]    f_tx;
    logic [T_W-1:0]    f_ty;
    logic              f_nx;
    logic              f_ny;
    logic [T_W-1:0]    f_dx;
    logic [T_W-1:0]    f_dy;
    t_sqrt_st          r_fwx;
    t_sqrt_st          r_fwy;
    t_sqrt_st          wx    [W_STEPS+1];
    t_sqrt_st          wy    [W_STEPS+1];
    t_fside            r_ws  [W_STEPS+1];

    logic [S_W-1:0]    s_x;
    logic [S_W-1:0]    s_y;
    logic [OUT_W-1:0]  cu;
    logic [OUT_W-1:0]  cv;

    // handshake: the whole chain moves unless a finished result is held
    assign en         = !(r_vld[LAT-1] && i_out_stall);
    assign o_in_stall = !en;
    assign accept     = i_in_valid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_normals <= 1'b0;
            r_center_x    <= '0;
            r_center_y    <= '0;
            r_center_z    <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_USE_NORMALS: r_use_normals <= i_cfg_data[0];
                CFG_CENTER_X:    r_center_x    <= i_cfg_data;
                CFG_CENTER_Y:    r_center_y    <= i_cfg_data;
                CFG_CENTER_Z:    r_center_z    <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= accept;
            for (int i = 1; i < LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lst[0] <= i_is_last;
            for (int i = 1; i < LAT; i++) begin
                r_lst[i] <= r_lst[i-1];
            end
        end
    end

    // offset from centre, sign and magnitude
    assign in_v[0] = i_vec_x;
    assign in_v[1] = i_vec_y;
    assign in_v[2] = i_vec_z;
    assign cen[0]  = r_center_x;
    assign cen[1]  = r_center_y;
    assign cen[2]  = r_center_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a_d[i] = {in_v[i][IN_W-1], in_v[i]}
                   - (r_use_normals ? '0 : {cen[i][IN_W-1], cen[i]});
            if (r_use_normals && (i == 2)) begin
                a_d[i] = '0;
            end
            a_mag[i] = a_d[i][MAG_W-1] ? (~a_d[i] + 1'b1) : a_d[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_am     <= a_mag;
            r_aneg_x <= a_d[0][MAG_W-1];
            r_aneg_y <= a_d[1][MAG_W-1];
        end
    end

    // right shift so the largest magnitude drops below 2^30
    always_comb begin
        b_ov = r_am[0] | r_am[1] | r_am[2];
        priority if (b_ov[32]) begin
            b_rs = 2'd3;
        end else if (b_ov[31]) begin
            b_rs = 2'd2;
        end else if (b_ov[30]) begin
            b_rs = 2'd1;
        end else begin
            b_rs = 2'd0;
        end
        b_side.neg_x = r_aneg_x;
        b_side.neg_y = r_aneg_y;
        b_side.zero  = (b_ov == '0);
        b_side.nx    = (r_am[0] > MAG_W'(UNIT_Q16)) ? UNIT_Q16 : r_am[0][T_W-1:0];
        b_side.ny    = (r_am[1] > MAG_W'(UNIT_Q16)) ? UNIT_Q16 : r_am[1][T_W-1:0];
    end

    // left-shift stages bring the leading one to bit 29
    always_ff @(posedge i_clk) begin
        logic [NRM_W-1:0] ov;
        int               sh;
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_cm[0][i] <= NRM_W'(r_am[i] >> b_rs);
            end
            r_cs[0] <= b_side;
            for (int s = 0; s < NRM_STAGES; s++) begin
                ov = r_cm[s][0] | r_cm[s][1] | r_cm[s][2];
                sh = 16 >> s;
                for (int i = 0; i < 3; i++) begin
                    if ((ov >> (NRM_W - sh)) == '0) begin
                        r_cm[s+1][i] <= r_cm[s][i] << sh;
                    end else begin
                        r_cm[s+1][i] <= r_cm[s][i];
                    end
                end
                r_cs[s+1] <= r_cs[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_dsq[i] <= r_cm[NRM_STAGES][i] * r_cm[NRM_STAGES][i];
            end
            r_dm0   <= r_cm[NRM_STAGES][0];
            r_dm1   <= r_cm[NRM_STAGES][1];
            r_dside <= r_cs[NRM_STAGES];
        end
    end

    // sum of squares feeds the length square root
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_est.rad  <= {2'b00, (62'(r_dsq[0]) + 62'(r_dsq[1]) + 62'(r_dsq[2]))};
            r_est.rem  <= '0;
            r_est.root <= '0;
            r_mid[0].m0   <= r_dm0;
            r_mid[0].m1   <= r_dm1;
            r_mid[0].side <= r_dside;
            for (int j = 1; j <= LEN_STEPS; j++) begin
                r_mid[j] <= r_mid[j-1];
            end
        end
    end

    assign l_st[0] = r_est;

    for (genvar j = 0; j < LEN_STEPS; j++) begin : g_len
        smuv_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_st  (l_st[j]),
            .o_st  (l_st[j+1])
        );
    end

    assign dv[0] = {l_st[LEN_STEPS].root,
                    DIV_R_W'(r_mid[LEN_STEPS].m0), {Q_W{1'b0}},
                    DIV_R_W'(r_mid[LEN_STEPS].m1), {Q_W{1'b0}}};

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        smuv_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_st  (dv[j]),
            .o_st  (dv[j+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dvs[0] <= r_mid[LEN_STEPS].side;
            for (int j = 1; j < DIV_STEPS; j++) begin
                r_dvs[j] <= r_dvs[j-1];
            end
        end
    end

    // pick the magnitude per mode; zero offset maps to the up vector
    always_comb begin
        f_side = r_dvs[DIV_STEPS-1];
        priority if (r_use_normals) begin
            f_tx = f_side.nx;
            f_ty = f_side.ny;
            f_nx = f_side.neg_x;
            f_ny = f_side.neg_y;
        end else if (f_side.zero) begin
            f_tx = '0;
            f_ty = UNIT_Q16;
            f_nx = 1'b0;
            f_ny = 1'b0;
        end else begin
            f_tx = (dv[DIV_STEPS].qx > UNIT_Q16) ? UNIT_Q16 : dv[DIV_STEPS].qx;
            f_ty = (dv[DIV_STEPS].qy > UNIT_Q16) ? UNIT_Q16 : dv[DIV_STEPS].qy;
            f_nx = f_side.neg_x;
            f_ny = f_side.neg_y;
        end
        f_dx = UNIT_Q16 - f_tx;
        f_dy = UNIT_Q16 - f_ty;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fwx.rad  <= {f_dx, 15'b0, 32'b0};
            r_fwx.rem  <= '0;
            r_fwx.root <= '0;
            r_fwy.rad  <= {f_dy, 15'b0, 32'b0};
            r_fwy.rem  <= '0;
            r_fwy.root <= '0;
            r_ws[0].tx          <= f_tx[S_W-1:0];
            r_ws[0].ty          <= f_ty[S_W-1:0];
            r_ws[0].cx.far_side <= f_tx > HALF_Q16;
            r_ws[0].cx.neg      <= f_nx;
            r_ws[0].cy.far_side <= f_ty > HALF_Q16;
            r_ws[0].cy.neg      <= f_ny;
            for (int j = 1; j <= W_STEPS; j++) begin
                r_ws[j] <= r_ws[j-1];
            end
        end
    end

    assign wx[0] = r_fwx;
    assign wy[0] = r_fwy;

    for (genvar j = 0; j < W_STEPS; j++) begin : g_w
        smuv_sqrt_cell u_cell_x (
            .i_clk (i_clk),
            .i_en  (en),
            .i_st  (wx[j]),
            .o_st  (wx[j+1])
        );
        smuv_sqrt_cell u_cell_y (
            .i_clk (i_clk),
            .i_en  (en),
            .i_st  (wy[j]),
            .o_st  (wy[j+1])
        );
    end

    assign s_x = r_ws[W_STEPS].cx.far_side ? wx[W_STEPS].root[S_W-1:0] : r_ws[W_STEPS].tx;
    assign s_y = r_ws[W_STEPS].cy.far_side ? wy[W_STEPS].root[S_W-1:0] : r_ws[W_STEPS].ty;

    smuv_asin u_asin_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_t     (s_x),
        .i_ctl   (r_ws[W_STEPS].cx),
        .o_coord (cu)
    );

    smuv_asin u_asin_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_t     (s_y),
        .i_ctl   (r_ws[W_STEPS].cy),
        .o_coord (cv)
    );

    assign o_out_valid = r_vld[LAT-1];
    assign o_last_out  = r_lst[LAT-1];
    assign o_u_coord   = cu;
    assign o_v_coord   = signed'(OUT_W'(16'd0 - cv));

endmodule

// ===== rtl/smuv_sqrt_cell.sv =====
// smuv_sqrt_cell: one registered step of a digit-by-digit integer square root.
// Depends on smuv_pkg (t_sqrt_st).
module smuv_sqrt_cell import smuv_pkg::*; (
    input  logic     i_clk,
    input  logic     i_en,
    input  t_sqrt_st i_st,
    output t_sqrt_st o_st
);

    t_sqrt_st              r_st;
    t_sqrt_st              n_st;
    logic [SQ_REM_W-1:0]   rem_sh;
    logic [SQ_REM_W-1:0]   trial;
    logic                  ge;

    always_comb begin
        // bring in the next two radicand bits
        rem_sh     = {i_st.rem[SQ_REM_W-3:0], i_st.rad[SQ_RAD_W-1 -: 2]};
        trial      = {2'b00, i_st.root, 2'b01};
        ge         = rem_sh >= trial;
        n_st.rad   = {i_st.rad[SQ_RAD_W-3:0], 2'b00};
        n_st.rem   = ge ? (rem_sh - trial) : rem_sh;
        n_st.root  = {i_st.root[SQ_ROOT_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule

// ===== rtl/smuv_div_cell.sv =====
// smuv_div_cell: one registered restoring-division step for the x and y lanes,
// both divided by the same length. Depends on smuv_pkg (t_div_st).
module smuv_div_cell import smuv_pkg::*; (
    input  logic    i_clk,
    input  logic    i_en,
    input  t_div_st i_st,
    output t_div_st o_st
);

    t_div_st              r_st;
    t_div_st              n_st;
    logic                 ge_x;
    logic                 ge_y;
    logic [DIV_R_W-1:0]   rx_sub;
    logic [DIV_R_W-1:0]   ry_sub;

    always_comb begin
        ge_x     = i_st.rx >= i_st.len;
        ge_y     = i_st.ry >= i_st.len;
        rx_sub   = ge_x ? (i_st.rx - i_st.len) : i_st.rx;
        ry_sub   = ge_y ? (i_st.ry - i_st.len) : i_st.ry;
        // remainder stays below len, so the shift loses nothing
        n_st.len = i_st.len;
        n_st.rx  = {rx_sub[DIV_R_W-2:0], 1'b0};
        n_st.ry  = {ry_sub[DIV_R_W-2:0], 1'b0};
        n_st.qx  = {i_st.qx[Q_W-2:0], ge_x};
        n_st.qy  = {i_st.qy[Q_W-2:0], ge_y};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule

// ===== rtl/smuv_asin.sv =====
// smuv_asin: pipelined arcsine series and final Q1.15 coordinate for one lane.
// Depends on smuv_pkg (coefficients, t_asin_ctl).
module smuv_asin import smuv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [S_W-1:0]   i_t,
    input  t_asin_ctl        i_ctl,
    output logic [OUT_W-1:0] o_coord
);

    logic [29:0]       x_in;
    logic [59:0]       sq;
    logic [29:0]       r_x   [HORNER_STG+1];
    logic [28:0]       r_x2  [HORNER_STG];
    logic [30:0]       r_p   [HORNER_STG];
    t_asin_ctl         r_ctl [ASIN_STG-1];
    logic [30:0]       r_px;
    logic [29:0]       r_a;
    logic [60:0]       px;
    logic [59:0]       ap;
    logic [30:0]       g;
    logic [30:0]       a_full;
    logic [30:0]       q;
    logic [31:0]       rnd;
    logic [OUT_W:0]    c;
    logic [OUT_W-1:0]  r_out;
    logic [59:0]       hp    [HORNER_STG];

    assign x_in = {i_t, 14'b0};
    assign sq   = x_in * x_in;

    always_comb begin
        for (int j = 0; j < HORNER_STG; j++) begin
            hp[j] = ((j == 0) ? K11 : r_p[(j == 0) ? 0 : j - 1]) * r_x2[j];
        end
    end

    assign px = r_p[HORNER_STG-1] * r_x[HORNER_STG];
    assign ap = r_px * INV_PI_Q30;

    // far side: asin(t) = pi/2 - 2 asin(sqrt((1-t)/2))
    always_comb begin
        g = {r_a, 1'b0};
        if (r_ctl[ASIN_STG-2].far_side) begin
            a_full = (g >= Q30_HALF) ? '0 : (Q30_HALF - g);
        end else begin
            a_full = {1'b0, r_a};
        end
        q   = r_ctl[ASIN_STG-2].neg ? (Q30_HALF - a_full) : (Q30_HALF + a_full);
        rnd = {1'b0, q} + 32'h0000_4000;
        c   = rnd[31:15];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]  <= x_in;
            r_x2[0] <= sq[58:30];
            r_ctl[0] <= i_ctl;
            for (int j = 0; j < HORNER_STG; j++) begin
                r_p[j]   <= HORNER_K[j] + hp[j][59:30];
                r_x[j+1] <= r_x[j];
            end
            for (int j = 1; j < HORNER_STG; j++) begin
                r_x2[j] <= r_x2[j-1];
            end
            for (int j = 1; j < ASIN_STG - 1; j++) begin
                r_ctl[j] <= r_ctl[j-1];
            end
            r_px  <= px[60:30];
            r_a   <= ap[59:30];
            r_out <= (c > COORD_MAX) ? COORD_MAX[OUT_W-1:0] : c[OUT_W-1:0];
        end
    end

    assign o_coord = r_out;

endmodule

// ===== rtl/smuv_chk.sv =====
// smuv_chk: port-level assertions for sphere_map_uv_generator_top, bound to it.
// Depends on smuv_pkg (widths).
module smuv_chk import smuv_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [OUT_W-1:0]        o_u_coord,
    input logic signed [OUT_W-1:0] o_v_coord
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // input is only held back by a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    a_u_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_u_coord <= 16'd32768))
        else $error("u coordinate above one");

    a_v_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_v_coord == 16'sd0) || o_v_coord[OUT_W-1]))
        else $error("v coordinate above zero");

endmodule

bind sphere_map_uv_generator_top smuv_chk u_smuv_chk (.*);
